### hdl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_SAME(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed");

// condition implies consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed");

`endif

### hdl/wch_pkg.sv
// types and codes of the word count hash table
`timescale 1ns / 1ps

package wch_pkg;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_START,
      S_PROBE,
      S_CHECK
   } state_type;

   localparam logic [2:0] ST_NEW    = 3'd0;
   localparam logic [2:0] ST_INCR   = 3'd1;
   localparam logic [2:0] ST_FOUND  = 3'd2;
   localparam logic [2:0] ST_ABSENT = 3'd3;
   localparam logic [2:0] ST_FULL   = 3'd4;
   localparam logic [2:0] ST_LONG   = 3'd5;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   localparam int COUNT_W = 32;

endpackage

### hdl/wch_word_buf.sv
// byte collector with running position-weighted hash
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wch_word_buf #(
   parameter int MAX_WORD_BYTES = 32,
   parameter int HASH_W = 11,
   parameter int FILL_W = 6
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic                        clear,
   input  logic [7:0]                  char_byte,
   output logic [MAX_WORD_BYTES*8-1:0] word_data,
   output logic [FILL_W-1:0]           word_fill,
   output logic [HASH_W-1:0]           word_hash
);
   localparam int IDX_W = (MAX_WORD_BYTES > 1) ? $clog2(MAX_WORD_BYTES) : 1;

   logic [7:0]        buf_ff [MAX_WORD_BYTES];
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [HASH_W-1:0] hash_ff, hash_in;
   logic [FILL_W+7:0] prod;
   logic              room;

   assign room = fill_ff < FILL_W'(MAX_WORD_BYTES);
   assign prod = char_byte * fill_ff;

   always_comb begin
      fill_in = fill_ff;
      hash_in = hash_ff;
      if (clear) begin
         fill_in = '0;
         hash_in = '0;
      end else if (push) begin
         if (room) begin
            fill_in = fill_ff + FILL_W'(1);
            hash_in = hash_ff + HASH_W'(prod);
         end else begin
            // overflow mark
            fill_in = FILL_W'(MAX_WORD_BYTES + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         hash_ff <= '0;
      end else begin
         fill_ff <= fill_in;
         hash_ff <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !clear && room) begin
         buf_ff[fill_ff[IDX_W-1:0]] <= char_byte;
      end
   end

   for (genvar i = 0; i < MAX_WORD_BYTES; i++) begin : g_flat
      assign word_data[i*8 +: 8] = buf_ff[i];
   end

   assign word_fill = fill_ff;
   assign word_hash = hash_ff;

   `ASSERT_SAME(a_fill_range, clock, reset, 1'b1, fill_ff <= FILL_W'(MAX_WORD_BYTES + 1))
   `ASSERT_NEXT(a_clear_empties, clock, reset, clear, fill_ff == '0 && hash_ff == '0)

endmodule

### hdl/word_count_hash_table.sv
// word count hash table with linear probing over on-chip slot memories
// states: a byte that is not the last transfers in S_IDLE; a word end passes to S_START,
// then S_PROBE and S_CHECK once per slot probed (1 to TABLE_SIZE slots) until it resolves,
// or gives its result from S_START for an overlong word; a word end waits while a result is held
// throughput: one byte per cycle while in S_IDLE; each probe step is S_PROBE then S_CHECK (registered slot read)
// reset: synchronous; a clearing pass writes every slot once and empties the slot table
`timescale 1ns / 1ps
`include "assert_macros.svh"

module word_count_hash_table #(
   parameter int TABLE_SIZE = 2048,
   parameter int MAX_WORD_BYTES = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_opcode,
   input  logic [7:0]                  req_char_byte,
   input  logic                        req_last_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [2:0]                  rsp_status,
   output logic [wch_pkg::COUNT_W-1:0] rsp_word_count,
   output logic [10:0]                 rsp_slot_index,
   output logic [11:0]                 rsp_occupied_slots
);
   import wch_pkg::*;

   // table size is a power of two, the home slot is the low hash bits
   localparam int IDX_W  = $clog2(TABLE_SIZE);
   localparam int FILL_W = $clog2(MAX_WORD_BYTES + 2);
   localparam int META_W = FILL_W + COUNT_W;
   localparam int KEY_W  = MAX_WORD_BYTES * 8;

   state_type state_ff, state_in;

   logic [IDX_W-1:0]   j_ff, j_in;
   logic [IDX_W:0]     n_ff, n_in;
   logic [IDX_W-1:0]   clr_ff, clr_in;
   logic               op_ff, op_in;
   logic [IDX_W:0]     occ_ff, occ_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         status_ff, status_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0]   slot_ff, slot_in;

   logic [META_W-1:0]  meta_mem [TABLE_SIZE];
   logic [KEY_W-1:0]   key_mem [TABLE_SIZE];
   logic [META_W-1:0]  meta_rd_ff;
   logic [KEY_W-1:0]   key_rd_ff;

   logic               meta_we, key_we;
   logic [IDX_W-1:0]   meta_wa;
   logic [META_W-1:0]  meta_wd;

   logic               accept, wb_clear, load;
   logic [KEY_W-1:0]   wb_data;
   logic [FILL_W-1:0]  wb_fill;
   logic [IDX_W-1:0]   wb_hash;

   logic [FILL_W-1:0]  rd_len;
   logic [COUNT_W-1:0] rd_count, inc_count;
   logic               key_eq, empty, hit, last_probe, resolve;

   wch_word_buf #(
      .MAX_WORD_BYTES (MAX_WORD_BYTES),
      .HASH_W         (IDX_W),
      .FILL_W         (FILL_W)
   ) u_word_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .clear     (wb_clear),
      .char_byte (req_char_byte),
      .word_data (wb_data),
      .word_fill (wb_fill),
      .word_hash (wb_hash)
   );

   assign req_ready = (state_ff == S_IDLE) && !(req_last_byte && rsp_valid_ff);
   assign accept    = req_valid && req_ready;

   assign rd_len    = meta_rd_ff[META_W-1 -: FILL_W];
   assign rd_count  = meta_rd_ff[COUNT_W-1:0];
   assign inc_count = (rd_count == '1) ? rd_count : rd_count + COUNT_W'(1);

   always_comb begin
      key_eq = 1'b1;
      for (int i = 0; i < MAX_WORD_BYTES; i++) begin
         if (FILL_W'(i) < wb_fill && key_rd_ff[i*8 +: 8] != wb_data[i*8 +: 8]) begin
            key_eq = 1'b0;
         end
      end
   end

   assign empty      = rd_len == '0;
   assign hit        = !empty && rd_len == wb_fill && key_eq;
   assign last_probe = n_ff == (IDX_W+1)'(TABLE_SIZE - 1);
   assign resolve    = empty || hit || last_probe;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (clr_ff == IDX_W'(TABLE_SIZE - 1)) state_in = S_IDLE;
         S_IDLE:  if (accept && req_last_byte) state_in = S_START;
         S_START: state_in = (wb_fill > FILL_W'(MAX_WORD_BYTES)) ? S_IDLE : S_PROBE;
         S_PROBE: state_in = S_CHECK;
         S_CHECK: state_in = resolve ? S_IDLE : S_PROBE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      j_in         = j_ff;
      n_in         = n_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      occ_in       = occ_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      count_in     = count_ff;
      slot_in      = slot_ff;
      meta_we      = 1'b0;
      meta_wa      = j_ff;
      meta_wd      = '0;
      key_we       = 1'b0;
      wb_clear     = 1'b0;
      load         = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            meta_we = 1'b1;
            meta_wa = clr_ff;
            clr_in  = clr_ff + IDX_W'(1);
         end
         S_IDLE: begin
            if (accept && req_last_byte) op_in = req_opcode;
         end
         S_START: begin
            j_in = wb_hash;
            n_in = '0;
            if (wb_fill > FILL_W'(MAX_WORD_BYTES)) begin
               load      = 1'b1;
               status_in = ST_LONG;
               count_in  = '0;
               slot_in   = '0;
               wb_clear  = 1'b1;
            end
         end
         S_CHECK: begin
            if (resolve) begin
               load     = 1'b1;
               wb_clear = 1'b1;
               count_in = '0;
               slot_in  = '0;
               if (op_ff == OP_LOOKUP) begin
                  if (hit) begin
                     status_in = ST_FOUND;
                     count_in  = rd_count;
                     slot_in   = j_ff;
                  end else begin
                     status_in = ST_ABSENT;
                  end
               end else if (hit) begin
                  status_in = ST_INCR;
                  count_in  = inc_count;
                  slot_in   = j_ff;
                  meta_we   = 1'b1;
                  meta_wd   = {rd_len, inc_count};
               end else if (empty) begin
                  status_in = ST_NEW;
                  count_in  = COUNT_W'(1);
                  slot_in   = j_ff;
                  meta_we   = 1'b1;
                  meta_wd   = {wb_fill, COUNT_W'(1)};
                  key_we    = 1'b1;
                  occ_in    = occ_ff + (IDX_W+1)'(1);
               end else begin
                  status_in = ST_FULL;
               end
            end else begin
               j_in = j_ff + IDX_W'(1);
               n_in = n_ff + (IDX_W+1)'(1);
            end
         end
         default: ;
      endcase
      if (load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff      <= j_in;
      n_ff      <= n_in;
      op_ff     <= op_in;
      status_ff <= status_in;
      count_ff  <= count_in;
      slot_ff   <= slot_in;
   end

   // slot memories, registered read of the probed slot
   always_ff @(posedge clock) begin
      if (meta_we) meta_mem[meta_wa] <= meta_wd;
      meta_rd_ff <= meta_mem[j_ff];
   end

   always_ff @(posedge clock) begin
      if (key_we) key_mem[j_ff] <= wb_data;
      key_rd_ff <= key_mem[j_ff];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_word_count     = count_ff;
   assign rsp_slot_index     = 11'(slot_ff);
   assign rsp_occupied_slots = 12'(occ_ff);

   `ASSERT_SAME(a_load_slot_free, clock, reset, load, !rsp_valid_ff)
   `ASSERT_SAME(a_probe_bound, clock, reset, state_ff == S_CHECK, n_ff < (IDX_W+1)'(TABLE_SIZE))
   `ASSERT_NEXT(a_new_bumps_occ, clock, reset, key_we, occ_ff == $past(occ_ff) + (IDX_W+1)'(1))
   `ASSERT_SAME(a_no_req_while_busy, clock, reset, state_ff != S_IDLE, !req_ready)

endmodule

### bench/tb_word_count_hash_table.sv
// self-checking testbench for the word count hash table
`timescale 1ns / 1ps

module tb_word_count_hash_table;
   import wch_pkg::*;

   localparam int TS = 2048;
   localparam int MAXB = 32;
   localparam int POOL = 40;

   typedef struct packed {
      logic       op;
      logic [7:0] ch;
      logic       last;
   } byte_item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] count;
      logic [10:0] slot;
      logic [11:0] occ;
   } word_result_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_opcode = 1'b0;
   logic [7:0] req_char_byte = 8'd0;
   logic req_last_byte = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_status;
   logic [COUNT_W-1:0] rsp_word_count;
   logic [10:0] rsp_slot_index;
   logic [11:0] rsp_occupied_slots;

   word_count_hash_table dut (.*);

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // mirror of the slot table
   logic [7:0] key_store[TS][MAXB];
   int key_len[TS];
   logic [31:0] word_freq[TS];
   int distinct_words = 0;
   logic [7:0] word_bytes[MAXB];
   int word_fill = 0;
   logic [31:0] hash_sum = 0;

   byte_item_type pending_bytes[$];
   word_result_type results_due[$];
   byte_item_type on_bus;
   word_result_type want;
   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   logic [7:0] pool_bytes[POOL][40];
   int pool_len[POOL];

   function automatic void count_byte(byte_item_type it);
      int j, n, k;
      bit found, empty, same;
      word_result_type r;
      if (word_fill < MAXB) begin
         word_bytes[word_fill] = it.ch;
         hash_sum += 32'(it.ch * word_fill);
         word_fill++;
      end else begin
         word_fill = MAXB + 1;
      end
      if (!it.last) return;
      r = '0;
      if (word_fill > MAXB) begin
         r.status = ST_LONG;
      end else begin
         j = int'(hash_sum % TS);
         found = 0;
         empty = 0;
         for (n = 0; n < TS; n++) begin
            if (key_len[j] == 0) begin
               empty = 1;
               break;
            end
            same = (key_len[j] == word_fill);
            for (k = 0; k < word_fill && same; k++)
               if (key_store[j][k] != word_bytes[k]) same = 0;
            if (same) begin
               found = 1;
               break;
            end
            j = (j + 1 == TS) ? 0 : j + 1;
         end
         if (it.op == OP_LOOKUP) begin
            if (found) begin
               r.status = ST_FOUND;
               r.count = word_freq[j];
               r.slot = 11'(j);
            end else begin
               r.status = ST_ABSENT;
            end
         end else if (found) begin
            if (word_freq[j] != 32'hFFFF_FFFF) word_freq[j]++;
            r.status = ST_INCR;
            r.count = word_freq[j];
            r.slot = 11'(j);
         end else if (empty) begin
            for (k = 0; k < word_fill; k++) key_store[j][k] = word_bytes[k];
            key_len[j] = word_fill;
            word_freq[j] = 32'd1;
            distinct_words++;
            r.status = ST_NEW;
            r.count = 32'd1;
            r.slot = 11'(j);
         end else begin
            r.status = ST_FULL;
         end
      end
      r.occ = distinct_words[11:0];
      word_fill = 0;
      hash_sum = 0;
      results_due.push_back(r);
   endfunction

   // driver: predicts each byte at its transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) count_byte(on_bus);
         if (!req_valid || req_ready) begin
            if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               on_bus = pending_bytes.pop_front();
               req_valid <= 1'b1;
               req_opcode <= on_bus.op;
               req_char_byte <= on_bus.ch;
               req_last_byte <= on_bus.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               $error("result with nothing expected: status %0d", rsp_status);
               errors++;
            end else begin
               want = results_due.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  errors++;
               end
               if (rsp_word_count !== want.count) begin
                  $error("word_count: expected %0d, actual %0d", want.count, rsp_word_count);
                  errors++;
               end
               if (rsp_slot_index !== want.slot) begin
                  $error("slot_index: expected %0d, actual %0d", want.slot, rsp_slot_index);
                  errors++;
               end
               if (rsp_occupied_slots !== want.occ) begin
                  $error("occupied_slots: expected %0d, actual %0d", want.occ,
                         rsp_occupied_slots);
                  errors++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // earlier opcodes are random, only the final one decides
   task automatic add_word(input logic op, input logic [7:0] w[$]);
      int i;
      byte_item_type it;
      for (i = 0; i < w.size(); i++) begin
         it.op = (i == w.size() - 1) ? op : logic'($urandom_range(1));
         it.ch = w[i];
         it.last = (i == w.size() - 1);
         pending_bytes.push_back(it);
      end
   endtask

   task automatic drain();
      while (!(pending_bytes.size() == 0 && !req_valid && results_due.size() == 0))
         @(posedge clock);
   endtask

   // five byte word whose hash is exactly h, tagged by its first byte
   task automatic add_hashed_word(input logic [7:0] tag, input int h);
      logic [7:0] w[$];
      logic [7:0] b[5];
      int p, rem, v;
      rem = h;
      b[0] = tag;
      for (p = 4; p >= 1; p--) begin
         v = rem / p;
         if (v > 255) v = 255;
         b[p] = 8'(v);
         rem -= v * p;
      end
      w = {b[0], b[1], b[2], b[3], b[4]};
      add_word(OP_INSERT, w);
   endtask

   initial begin
      logic [7:0] w[$];
      int i, k, n, sel, items;
      logic op;
      for (i = 0; i < TS; i++) begin
         key_len[i] = 0;
         word_freq[i] = 32'd0;
      end
      for (i = 0; i < POOL; i++) begin
         pool_len[i] = ($urandom_range(9) == 0) ? $urandom_range(40, 28) : $urandom_range(8, 1);
         for (k = 0; k < pool_len[i]; k++) pool_bytes[i][k] = 8'($urandom_range(255));
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: extreme bytes, both ops, zero byte, opcode of last byte only
      add_word(OP_INSERT, '{8'hFF});
      add_word(OP_INSERT, '{8'hFF});
      add_word(OP_LOOKUP, '{8'hFF});
      add_word(OP_LOOKUP, '{8'h00});
      add_word(OP_INSERT, '{8'h00});
      add_word(OP_INSERT, '{8'h01, 8'h00, 8'hFF});
      add_word(OP_LOOKUP, '{8'h01, 8'h00, 8'hFF});
      add_word(OP_INSERT, '{8'hAA, 8'h55});
      add_word(OP_LOOKUP, '{8'h55, 8'hAA});
      add_word(OP_INSERT, '{8'h80});
      add_word(OP_LOOKUP, '{8'h80});
      drain();

      // random words, mostly from a small pool so counts climb
      items = 0;
      while (items < 1700) begin
         case ((items * 4) / 1700)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 50; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 50; end
            default: begin send_idle_pct = 33; recv_stall_pct = 33; end
         endcase
         w = {};
         sel = $urandom_range(99);
         if (sel < 85) begin
            n = $urandom_range(POOL - 1);
            for (k = 0; k < pool_len[n]; k++) w.push_back(pool_bytes[n][k]);
         end else begin
            n = (sel < 92) ? $urandom_range(36, 30) : $urandom_range(6, 1);
            for (k = 0; k < n; k++) w.push_back(8'($urandom_range(255)));
         end
         op = ($urandom_range(2) == 0) ? OP_LOOKUP : OP_INSERT;
         add_word(op, w);
         items += w.size();
         if (pending_bytes.size() > 64) begin
            while (pending_bytes.size() > 16) @(posedge clock);
         end
      end
      drain();

      // a found and an absent lookup, a zero run and a word at a chosen home slot
      send_idle_pct = 0;
      recv_stall_pct = 0;
      add_word(OP_INSERT, '{8'hEE, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05});
      add_word(OP_INSERT, '{8'hEF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
      add_word(OP_LOOKUP, '{8'hEE, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05});
      add_hashed_word(8'd1, 100);
      w = {8'd1, 8'd0, 8'd0, 8'd0, 8'd0};
      add_word(OP_LOOKUP, w);
      drain();

      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
